// ===== rtl/core/query_id_translation_table_macros.svh =====
// ----------------------------------------------------------------------------
// Query ID translation table: assertion macros
// Shared property forms for the checker. Both expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef QUERY_ID_TRANSLATION_TABLE_MACROS_SVH
`define QUERY_ID_TRANSLATION_TABLE_MACROS_SVH

// consequent in the same cycle
`define QIDT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the following cycle
`define QIDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/qidt_pkg.sv =====
// ----------------------------------------------------------------------------
// Query ID translation table: package
// Operation and status codes, register indexes, control types, ID generator.
// ----------------------------------------------------------------------------
package qidt_pkg;

  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_CANCEL = 2'd2;
  localparam logic [1:0] FUNC_FLUSH  = 2'd3;

  localparam logic [2:0] ST_NEW   = 3'd0;
  localparam logic [2:0] ST_RETRY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_HIT   = 3'd3;
  localparam logic [2:0] ST_MISS  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd1;

  localparam logic [15:0] TIMEOUT_RST = 16'd40;
  localparam logic [15:0] LFSR_RST    = 16'd1;
  localparam logic [15:0] LFSR_MASK   = 16'hB400;

  typedef struct packed {
    logic load;
    logic clr;
    logic issue;
    logic track;
    logic redraw;
    logic commit;
  } qidt_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic flush_req;
    logic redraw;
  } qidt_stat_t;

  // Galois step, zero forced to one
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) begin
      s = s ^ LFSR_MASK;
    end
    if (s == 16'd0) begin
      s = 16'd1;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/qidt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Query ID translation table: controller
// Sequences clearing sweeps, table scans, ID redraws and the commit beat.
// ----------------------------------------------------------------------------
module qidt_ctrl
  import qidt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  qidt_stat_t stat,
  output qidt_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       rslt_r, rslt_nxt;
  logic       first_r, first_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    rslt_nxt  = rslt_r;
    first_nxt = first_r;
    cmd       = '0;
    cmd.track = first_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.flush_req) begin
            rslt_nxt  = 1'b1;
            state_nxt = S_CLEAR;
          end else begin
            first_nxt = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.cnt_last) begin
          rslt_nxt  = 1'b0;
          state_nxt = rslt_r ? S_FINISH : S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.redraw) begin
          cmd.redraw = 1'b1;
          first_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      rslt_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rslt_r  <= rslt_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

// ===== rtl/core/qidt_dp.sv =====
// ----------------------------------------------------------------------------
// Query ID translation table: datapath
// Entry memories, scan trackers, ID generator, config and result registers.
// ----------------------------------------------------------------------------
module qidt_dp
  import qidt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qidt_cmd_t            cmd,
  output qidt_stat_t           stat,
  input  logic [1:0]           in_func,
  input  logic [15:0]          in_query_id,
  input  logic [47:0]          in_source_key,
  input  logic [15:0]          in_reply_tag,
  input  logic [31:0]          in_now,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [15:0]          out_id_out,
  output logic [47:0]          out_source_key_out,
  output logic [15:0]          out_reply_tag_out,
  output logic [5:0]           out_slot
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = 16 + 48 + 16 + 32;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  logic [15:0]   oid_mem [TABLE_DEPTH];
  logic [DW-1:0] dat_mem [TABLE_DEPTH];

  logic [1:0]    func_r;
  logic [15:0]   qid_r;
  logic [47:0]   key_r;
  logic [15:0]   tag_r;
  logic [31:0]   now_r;

  logic [AW-1:0] cnt_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic [15:0]   oid_q;
  logic [DW-1:0] dat_q;

  logic          hit_r, free_r, old_r, coll_r;
  logic [AW-1:0] hit_idx_r, free_idx_r, old_idx_r;
  logic [15:0]   hit_oid_r, hit_orig_r, hit_tag_r;
  logic [47:0]   hit_src_r;
  logic [31:0]   oldtime_r;
  logic [15:0]   cand_r;
  logic [15:0]   lfsr_r;
  logic [15:0]   timeout_r;

  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [15:0]   out_id_r;
  logic [47:0]   out_key_r;
  logic [15:0]   out_tag_r;
  logic [5:0]    out_slot_r;

  logic [15:0]   e_orig, e_tag;
  logic [47:0]   e_src;
  logic [31:0]   e_stamp;
  logic          e_busy, m_alloc, m_look, m_any;
  logic [31:0]   age;
  logic          pick_ok;
  logic [AW-1:0] pick_idx;

  logic          oid_we, dat_we, lfsr_we;
  logic [AW-1:0] oid_wa;
  logic [15:0]   oid_wd;
  logic [2:0]    res_status;
  logic [15:0]   res_id, res_tag;
  logic [47:0]   res_key;
  logic [5:0]    res_slot;

  assign e_orig  = dat_q[111:96];
  assign e_src   = dat_q[95:48];
  assign e_tag   = dat_q[47:32];
  assign e_stamp = dat_q[31:0];

  assign e_busy  = (oid_q != 16'd0);
  assign m_alloc = e_busy && (e_orig == qid_r) && (e_src == key_r);
  assign m_look  = (qid_r != 16'd0) && (oid_q == qid_r);
  assign m_any   = (func_r == FUNC_ALLOC) ? m_alloc : m_look;

  assign age      = now_r - oldtime_r;
  assign pick_ok  = free_r || (old_r && (age > {16'd0, timeout_r}));
  assign pick_idx = free_r ? free_idx_r : old_idx_r;

  assign stat.cnt_last  = (cnt_r == LAST_IDX);
  assign stat.flush_req = (in_func == FUNC_FLUSH);
  assign stat.redraw    = (func_r == FUNC_ALLOC) && !hit_r && pick_ok && coll_r;

  always_comb begin
    oid_we     = cmd.clr;
    oid_wa     = cnt_r;
    oid_wd     = 16'd0;
    dat_we     = 1'b0;
    lfsr_we    = 1'b0;
    res_status = ST_DONE;
    res_id     = 16'd0;
    res_key    = 48'd0;
    res_tag    = 16'd0;
    res_slot   = 6'd0;
    unique case (func_r) inside
      FUNC_ALLOC: begin
        if (hit_r) begin
          res_status = ST_RETRY;
          res_id     = hit_oid_r;
          res_slot   = 6'(hit_idx_r);
        end else if (!pick_ok) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_NEW;
          res_id     = cand_r;
          res_slot   = 6'(pick_idx);
          if (cmd.commit) begin
            oid_we  = 1'b1;
            oid_wa  = pick_idx;
            oid_wd  = cand_r;
            dat_we  = 1'b1;
            lfsr_we = 1'b1;
          end
        end
      end
      FUNC_LOOKUP, FUNC_CANCEL: begin
        if (hit_r) begin
          res_status = ST_HIT;
          res_id     = hit_orig_r;
          res_slot   = 6'(hit_idx_r);
          if (func_r == FUNC_LOOKUP) begin
            res_key = hit_src_r;
            res_tag = hit_tag_r;
          end
          if (cmd.commit) begin
            oid_we = 1'b1;
            oid_wa = hit_idx_r;
          end
        end else begin
          res_status = ST_MISS;
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  // entry memories
  always_ff @(posedge clk) begin
    if (oid_we) begin
      oid_mem[oid_wa] <= oid_wd;
    end
    if (cmd.issue) begin
      oid_q <= oid_mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (dat_we) begin
      dat_mem[pick_idx] <= {qid_r, key_r, tag_r, now_r};
    end
    if (cmd.issue) begin
      dat_q <= dat_mem[cnt_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      old_r       <= 1'b0;
      coll_r      <= 1'b0;
      lfsr_r      <= LFSR_RST;
      timeout_r   <= TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.issue;
      out_valid_r <= cmd.commit;
      if (cmd.load || cmd.redraw) begin
        cnt_r <= '0;
      end else if (cmd.clr || cmd.issue) begin
        cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + AW'(1);
      end
      if (cmd.load) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        old_r  <= 1'b0;
        coll_r <= 1'b0;
      end else begin
        if (cmd.redraw) begin
          coll_r <= 1'b0;
        end
        if (rd_vld_r) begin
          if (e_busy && (oid_q == cand_r)) begin
            coll_r <= 1'b1;
          end
          if (cmd.track) begin
            if (m_any) begin
              hit_r <= 1'b1;
            end
            if (!e_busy) begin
              free_r <= 1'b1;
            end
            if (e_stamp <= oldtime_r) begin
              old_r <= 1'b1;
            end
          end
        end
      end
      if (lfsr_we) begin
        lfsr_r <= cand_r;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_data;
          CFG_SEED:    lfsr_r    <= (cfg_data == 16'd0) ? LFSR_RST : cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (cmd.load) begin
      func_r    <= in_func;
      qid_r     <= in_query_id;
      key_r     <= in_source_key;
      tag_r     <= in_reply_tag;
      now_r     <= in_now;
      oldtime_r <= in_now;
      cand_r    <= lfsr_next(lfsr_r);
    end else begin
      if (cmd.redraw) begin
        cand_r <= lfsr_next(cand_r);
      end
      if (rd_vld_r && cmd.track) begin
        if (m_any && !hit_r) begin
          hit_idx_r  <= rd_idx_r;
          hit_oid_r  <= oid_q;
          hit_orig_r <= e_orig;
          hit_src_r  <= e_src;
          hit_tag_r  <= e_tag;
        end
        if (!e_busy && !free_r) begin
          free_idx_r <= rd_idx_r;
        end
        if (e_stamp <= oldtime_r) begin
          oldtime_r <= e_stamp;
          old_idx_r <= rd_idx_r;
        end
      end
    end
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_key_r    <= res_key;
      out_tag_r    <= res_tag;
      out_slot_r   <= res_slot;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_id_out         = out_id_r;
  assign out_source_key_out = out_key_r;
  assign out_reply_tag_out  = out_tag_r;
  assign out_slot           = out_slot_r;

endmodule

// ===== rtl/core/query_id_translation_table.sv =====
// ----------------------------------------------------------------------------
// Query ID translation table
// Table of pending forwarded queries: allocate, reply lookup, cancel, flush.
//
//   channel  ports                          beat taken when
//   input    start, busy, in_*              start high, busy low
//   result   out_valid, out_*               out_valid high, one cycle
//   config   cfg_valid, cfg_ready, cfg_*    cfg_valid and cfg_ready high
//
// Allocate, lookup and cancel read the entry memories once per entry; an
// allocate rescans the table for each ID redraw on a collision. Flush sweeps
// the table. After reset a clearing sweep runs with busy high.
// busy stays high until the result beat; results cannot be stalled.
// ----------------------------------------------------------------------------
module query_id_translation_table
  import qidt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_func,
  input  logic [15:0]          in_query_id,
  input  logic [47:0]          in_source_key,
  input  logic [15:0]          in_reply_tag,
  input  logic [31:0]          in_now,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [15:0]          out_id_out,
  output logic [47:0]          out_source_key_out,
  output logic [15:0]          out_reply_tag_out,
  output logic [5:0]           out_slot,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  qidt_cmd_t  cmd;
  qidt_stat_t stat;

  assign cfg_ready = 1'b1;

  qidt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  qidt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_func            (in_func),
    .in_query_id        (in_query_id),
    .in_source_key      (in_source_key),
    .in_reply_tag       (in_reply_tag),
    .in_now             (in_now),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_id_out         (out_id_out),
    .out_source_key_out (out_source_key_out),
    .out_reply_tag_out  (out_reply_tag_out),
    .out_slot           (out_slot)
  );

endmodule

// ===== rtl/core/qidt_chk.sv =====
// ----------------------------------------------------------------------------
// Query ID translation table: port checker
// Watches the top-level ports and checks result beats against their status.
// ----------------------------------------------------------------------------
`include "query_id_translation_table_macros.svh"

module qidt_chk
  import qidt_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [2:0]           out_status,
  input logic [15:0]          out_id_out,
  input logic [47:0]          out_source_key_out,
  input logic [15:0]          out_reply_tag_out,
  input logic [5:0]           out_slot,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  logic empty_rslt;

  assign empty_rslt = (out_status == ST_FULL) || (out_status == ST_MISS) ||
                      (out_status == ST_DONE);

  `QIDT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `QIDT_ASSERT_NEXT(a_single_beat, out_valid, !out_valid, "result beat longer than one cycle")
  `QIDT_ASSERT_SAME(a_new_id_nz, out_valid && (out_status == ST_NEW), out_id_out != 16'd0, "new entry with zero id")
  `QIDT_ASSERT_SAME(a_key_on_hit, out_valid && (out_status != ST_HIT), (out_source_key_out == 48'd0) && (out_reply_tag_out == 16'd0), "key or tag outside a hit")
  `QIDT_ASSERT_SAME(a_empty_rslt, out_valid && empty_rslt, (out_id_out == 16'd0) && (out_slot == 6'd0) && (cfg_ready || !cfg_valid), "fields set on full, miss or done")

endmodule

bind query_id_translation_table qidt_chk u_qidt_chk (.*);
